// ----- rtl/a2i_pkg.sv -----
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared types and constants for the streaming ASCII to 64-bit integer parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

    // Datapath widths fixed by the item format.
    localparam int ACC_W      = 64;
    localparam int BASE_W     = 6;
    localparam int CH_W       = 8;
    localparam int OFS_W      = 8;
    localparam int PROD_W     = ACC_W + BASE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Parser phase codes.
    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_XSEEN  = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 1'b1;

    // Character codes.
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_OFS = 8'h37;  // 'A' - 10
    localparam logic [CH_W-1:0] CH_LO_OFS = 8'h57;  // 'a' - 10
    localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

    // Bases with a special meaning.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    // Saturation limits.
    localparam logic [ACC_W-1:0] LIM_NEG = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    // Parser control state, apart from the accumulator and the offset count.
    typedef struct packed {
        logic [2:0]        phase;
        logic              negative;
        logic [BASE_W-1:0] base;
        logic              seen;
        logic              over;
    } ctl_t;

    // One result item.
    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [OFS_W-1:0] end_offset;
        logic             any_digits;
        logic             overflow;
    } result_t;

endpackage

// ----- rtl/a2i_if.sv -----
// ----------------------------------------------------------------------------
// a2i_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface a2i_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface a2i_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [7:0]  end_offset;
    logic        any_digits;
    logic        overflow;

    modport source (output valid, output value, output end_offset, output any_digits,
                    output overflow, input ready);
    modport sink   (input valid, input value, input end_offset, input any_digits,
                    input overflow, output ready);
endinterface

// ----- rtl/a2i_step.sv -----
// ----------------------------------------------------------------------------
// a2i_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
module a2i_step #(
    parameter int CNT_W      = 8,
    parameter int MAX_OFFSET = 255
) (
    input  logic [a2i_pkg::CH_W-1:0]   ch,
    input  logic                       first,
    input  logic [a2i_pkg::BASE_W-1:0] radix,
    input  logic                       signed_mode,
    input  a2i_pkg::ctl_t              ctl_cur,
    input  logic [a2i_pkg::ACC_W-1:0]  acc_cur,
    input  logic [CNT_W-1:0]           cnt_cur,
    output a2i_pkg::ctl_t              ctl_next,
    output logic [a2i_pkg::ACC_W-1:0]  acc_next,
    output logic [CNT_W-1:0]           cnt_next,
    output logic                       emit,
    output a2i_pkg::result_t           res
);

    localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(MAX_OFFSET);

    a2i_pkg::ctl_t               ctl_eff;
    logic [a2i_pkg::ACC_W-1:0]   acc_eff;
    logic [CNT_W-1:0]            cnt_eff;
    logic [a2i_pkg::BASE_W-1:0]  mul_base;
    logic [a2i_pkg::BASE_W-1:0]  dig;
    logic                        dig_ok;
    logic                        is_space;
    logic                        bad_radix;
    logic [a2i_pkg::PROD_W-1:0]  prod;
    logic [CNT_W-1:0]            cnt_inc1;
    logic [CNT_W-1:0]            cnt_inc2;
    logic [CNT_W-1:0]            end_pos;
    logic [a2i_pkg::ACC_W-1:0]   lim;
    logic [a2i_pkg::ACC_W-1:0]   signed_val;
    logic [a2i_pkg::ACC_W-1:0]   out_val;
    logic                        out_ov;
    logic                        body;
    logic                        dstep;
    logic                        acc_do;

    // Saturating add of a small step to the character offset.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(n);
        if (s > CNT_LIMIT) begin
            s = CNT_LIMIT;
        end
        return s[CNT_W-1:0];
    endfunction

    // A start flag begins from a fresh state with the base latched from radix.
    always_comb
    begin
        if (first)
        begin
            ctl_eff.phase    = a2i_pkg::PH_LEAD;
            ctl_eff.negative = 1'b0;
            ctl_eff.base     = radix;
            ctl_eff.seen     = 1'b0;
            ctl_eff.over     = 1'b0;
            acc_eff          = '0;
            cnt_eff          = '0;
        end
        else
        begin
            ctl_eff = ctl_cur;
            acc_eff = acc_cur;
            cnt_eff = cnt_cur;
        end
    end

    assign bad_radix = (radix == a2i_pkg::BASE_ONE) || (radix > a2i_pkg::BASE_MAX);
    assign is_space  = (ch == a2i_pkg::CH_SPACE) ||
                       ((ch >= a2i_pkg::CH_TAB) && (ch <= a2i_pkg::CH_CR));
    assign cnt_inc1  = sat_add(cnt_eff, 2'd1);
    assign cnt_inc2  = sat_add(cnt_eff, 2'd2);

    // Digit value of the character; bytes above 127 fall outside every range.
    always_comb
    begin
        dig    = '0;
        dig_ok = 1'b0;
        if ((ch >= a2i_pkg::CH_ZERO) && (ch <= a2i_pkg::CH_NINE))
        begin
            dig    = a2i_pkg::BASE_W'(ch - a2i_pkg::CH_ZERO);
            dig_ok = 1'b1;
        end
        else if ((ch >= a2i_pkg::CH_UP_A) && (ch <= a2i_pkg::CH_UP_Z))
        begin
            dig    = a2i_pkg::BASE_W'(ch - a2i_pkg::CH_UP_OFS);
            dig_ok = 1'b1;
        end
        else if ((ch >= a2i_pkg::CH_LO_A) && (ch <= a2i_pkg::CH_LO_Z))
        begin
            dig    = a2i_pkg::BASE_W'(ch - a2i_pkg::CH_LO_OFS);
            dig_ok = 1'b1;
        end
    end

    // Base used for a digit on this character, after any prefix default.
    always_comb
    begin
        if (ctl_eff.phase == a2i_pkg::PH_XSEEN)
        begin
            mul_base = a2i_pkg::BASE_HEX;
        end
        else if (ctl_eff.base == a2i_pkg::BASE_AUTO)
        begin
            mul_base = (ctl_eff.phase == a2i_pkg::PH_ZERO) ? a2i_pkg::BASE_OCT
                                                           : a2i_pkg::BASE_DEC;
        end
        else
        begin
            mul_base = ctl_eff.base;
        end
    end

    // Multiply-accumulate; any bit above bit 63 means the value no longer fits.
    assign prod = a2i_pkg::PROD_W'(acc_eff) * a2i_pkg::PROD_W'(mul_base) +
                  a2i_pkg::PROD_W'(dig);

    // Result value with sign and saturation applied.
    always_comb
    begin
        lim        = ctl_eff.negative ? a2i_pkg::LIM_NEG : a2i_pkg::LIM_POS;
        signed_val = ctl_eff.negative ? (~acc_eff + 64'd1) : acc_eff;
        out_val    = '0;
        out_ov     = 1'b0;
        if (ctl_eff.seen)
        begin
            if (signed_mode)
            begin
                out_ov  = ctl_eff.over || (acc_eff > lim);
                out_val = out_ov ? lim : signed_val;
            end
            else
            begin
                out_ov  = ctl_eff.over;
                out_val = out_ov ? '1 : signed_val;
            end
        end
    end

    // Phase sequencing for one character.
    always_comb
    begin
        ctl_next = ctl_eff;
        acc_next = acc_eff;
        cnt_next = cnt_eff;
        emit     = 1'b0;
        body     = 1'b0;
        dstep    = 1'b0;
        acc_do   = 1'b0;

        if (first && bad_radix)
        begin
            emit = 1'b1;
        end
        else
        begin
            case (ctl_eff.phase)
                a2i_pkg::PH_LEAD:
                begin
                    if (is_space)
                    begin
                        cnt_next = cnt_inc1;
                    end
                    else if (ch == a2i_pkg::CH_MINUS)
                    begin
                        ctl_next.negative = 1'b1;
                        cnt_next          = cnt_inc1;
                        ctl_next.phase    = a2i_pkg::PH_SIGNED;
                    end
                    else if (ch == a2i_pkg::CH_PLUS)
                    begin
                        cnt_next       = cnt_inc1;
                        ctl_next.phase = a2i_pkg::PH_SIGNED;
                    end
                    else
                    begin
                        body = 1'b1;
                    end
                end
                a2i_pkg::PH_SIGNED:
                begin
                    body = 1'b1;
                end
                a2i_pkg::PH_ZERO:
                begin
                    if ((ch == a2i_pkg::CH_LO_X) || (ch == a2i_pkg::CH_UP_X))
                    begin
                        ctl_next.base  = a2i_pkg::BASE_HEX;
                        ctl_next.phase = a2i_pkg::PH_XSEEN;
                    end
                    else
                    begin
                        ctl_next.base = mul_base;
                        dstep         = 1'b1;
                    end
                end
                a2i_pkg::PH_XSEEN:
                begin
                    if (dig_ok && (dig < a2i_pkg::BASE_HEX))
                    begin
                        acc_do         = 1'b1;
                        cnt_next       = cnt_inc2;
                        ctl_next.phase = a2i_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                a2i_pkg::PH_DIGITS:
                begin
                    dstep = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Start of the number body: a leading zero may open a prefix.
        if (body)
        begin
            if (((ctl_eff.base == a2i_pkg::BASE_AUTO) || (ctl_eff.base == a2i_pkg::BASE_HEX)) &&
                (ch == a2i_pkg::CH_ZERO))
            begin
                acc_next       = '0;
                ctl_next.seen  = 1'b1;
                cnt_next       = cnt_inc1;
                ctl_next.phase = a2i_pkg::PH_ZERO;
            end
            else
            begin
                ctl_next.base = mul_base;
                dstep         = 1'b1;
            end
        end

        // Plain digit in the active base, or the end of the number.
        if (dstep)
        begin
            if (dig_ok && (dig < mul_base))
            begin
                acc_do         = 1'b1;
                cnt_next       = cnt_inc1;
                ctl_next.phase = a2i_pkg::PH_DIGITS;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        // Accumulate; once overflowed the magnitude is frozen.
        if (acc_do)
        begin
            ctl_next.seen = 1'b1;
            if (!ctl_eff.over && (mul_base != a2i_pkg::BASE_AUTO))
            begin
                if (prod[a2i_pkg::PROD_W-1:a2i_pkg::ACC_W] != '0)
                begin
                    ctl_next.over = 1'b1;
                end
                else
                begin
                    acc_next = prod[a2i_pkg::ACC_W-1:0];
                end
            end
        end

        if (emit)
        begin
            ctl_next.phase = a2i_pkg::PH_DONE;
        end
    end

    // Without any digit the end offset reads as zero.
    assign end_pos        = ctl_eff.seen ? cnt_eff : '0;
    assign res.value      = out_val;
    assign res.end_offset = a2i_pkg::OFS_W'(end_pos);
    assign res.any_digits = ctl_eff.seen;
    assign res.overflow   = out_ov;

endmodule

// ----- rtl/ascii_to_int64_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_to_int64_parser
// Streaming strtoll/strtoull style parser: one character per item in, one
// result item out when the number ends.
// ----------------------------------------------------------------------------
// A character is taken into the input register when it is accepted; the result
// register captures the result of its ending character when the input stage
// moves on, which a stalled output can hold back.
// Throughput: one character per cycle while the result side is not stalled;
// the 64x6 multiply-accumulate and range check sit between the two registers.
// Reset: rst_n clears all valids, the parse state (awaiting a start flag),
// and the registers (radix 0, signed_mode 1).
module ascii_to_int64_parser #(
    parameter int MAX_OFFSET = 255
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [a2i_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [a2i_pkg::CFG_DATA_W-1:0] cfg_data,
    a2i_in_if.sink                         din,
    a2i_out_if.source                      dout
);

    localparam int CNT_W = $clog2(MAX_OFFSET + 1);

    logic [a2i_pkg::BASE_W-1:0] radix_reg;
    logic                       signed_mode_reg;

    logic                       s1_valid_reg;
    logic [a2i_pkg::CH_W-1:0]   s1_ch_reg;
    logic                       s1_first_reg;
    logic                       s1_go;

    a2i_pkg::ctl_t              ctl_reg;
    a2i_pkg::ctl_t              ctl_next;
    logic [a2i_pkg::ACC_W-1:0]  acc_reg;
    logic [a2i_pkg::ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;

    logic                       emit;
    a2i_pkg::result_t           res_next;
    a2i_pkg::result_t           res_reg;
    logic                       out_valid_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= a2i_pkg::BASE_AUTO;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                a2i_pkg::REG_RADIX:  radix_reg       <= cfg_data;
                a2i_pkg::REG_SIGNED: signed_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // The input stage moves on when the result register is empty or draining.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || s1_go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            s1_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.ready && din.valid)
        begin
            s1_ch_reg    <= din.ch;
            s1_first_reg <= din.first;
        end
    end

    // Per-character step logic.
    a2i_step #(
        .CNT_W      (CNT_W),
        .MAX_OFFSET (MAX_OFFSET)
    ) u_step (
        .ch          (s1_ch_reg),
        .first       (s1_first_reg),
        .radix       (radix_reg),
        .signed_mode (signed_mode_reg),
        .ctl_cur     (ctl_reg),
        .acc_cur     (acc_reg),
        .cnt_cur     (cnt_reg),
        .ctl_next    (ctl_next),
        .acc_next    (acc_next),
        .cnt_next    (cnt_next),
        .emit        (emit),
        .res         (res_next)
    );

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase    <= a2i_pkg::PH_DONE;
            ctl_reg.negative <= 1'b0;
            ctl_reg.base     <= a2i_pkg::BASE_AUTO;
            ctl_reg.seen     <= 1'b0;
            ctl_reg.over     <= 1'b0;
            acc_reg          <= '0;
            cnt_reg          <= '0;
        end
        else if (s1_go)
        begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= emit;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.value      = res_reg.value;
    assign dout.end_offset = res_reg.end_offset;
    assign dout.any_digits = res_reg.any_digits;
    assign dout.overflow   = res_reg.overflow;

endmodule

// ----- rtl/a2i_checker.sv -----
// ----------------------------------------------------------------------------
// a2i_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module a2i_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_value,
    input logic [7:0]  out_end_offset,
    input logic        out_any_digits,
    input logic        out_overflow
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_end_offset))
        else $error("result item changed while stalled");

    // A string with no digits reports zero and no end offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_any_digits |->
            (out_value == 64'd0) && (out_end_offset == 8'd0) && !out_overflow)
        else $error("empty parse reported a nonzero field");

    // Overflow can only follow converted digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overflow |-> out_any_digits)
        else $error("overflow without digits");

endmodule

bind ascii_to_int64_parser a2i_checker u_a2i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_value      (dout.value),
    .out_end_offset (dout.end_offset),
    .out_any_digits (dout.any_digits),
    .out_overflow   (dout.overflow)
);

// ----- test/ascii_to_int64_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_to_int64_parser_tb
// Feeds character strings through the parser and checks every parse result
// against a cycle-free model of the strtoll/strtoull rules kept in the bench.
// Directed strings and a saturated end offset come first, then random numbers
// in eight radix settings, a long output hold-off and an unterminated string.
// ----------------------------------------------------------------------------
module ascii_to_int64_parser_tb;

    localparam int OFFSET_CAP   = 255;
    localparam int SETTLE_CYC   = 4;
    localparam int NOT_A_DIGIT  = 99;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [a2i_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [a2i_pkg::CFG_DATA_W-1:0] cfg_data;

    a2i_in_if  chars ();
    a2i_out_if results ();

    ascii_to_int64_parser #(
        .MAX_OFFSET (OFFSET_CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (chars),
        .dout      (results)
    );

    // Register copies, at their reset values.
    logic [a2i_pkg::BASE_W-1:0] cfg_radix  = a2i_pkg::BASE_AUTO;
    logic                       cfg_signed = 1'b1;

    // Parser state of the model.
    logic [a2i_pkg::ACC_W-1:0]  p_acc   = '0;
    logic                       p_neg   = 1'b0;
    logic [2:0]                 p_phase = a2i_pkg::PH_DONE;
    logic [a2i_pkg::BASE_W-1:0] p_base  = '0;
    logic                       p_seen  = 1'b0;
    logic                       p_over  = 1'b0;
    int unsigned                p_count = 0;

    a2i_pkg::result_t parse_q[$];

    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;
    int hold_cycles = 0;

    int fail_count   = 0;
    int chars_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic int unsigned digit_value(input logic [7:0] c);
        if (c >= a2i_pkg::CH_ZERO && c <= a2i_pkg::CH_NINE) return c - a2i_pkg::CH_ZERO;
        if (c >= a2i_pkg::CH_UP_A && c <= a2i_pkg::CH_UP_Z) return c - a2i_pkg::CH_UP_OFS;
        if (c >= a2i_pkg::CH_LO_A && c <= a2i_pkg::CH_LO_Z) return c - a2i_pkg::CH_LO_OFS;
        return NOT_A_DIGIT;
    endfunction

    function automatic void bump(input int unsigned n);
        p_count = (p_count + n > OFFSET_CAP) ? OFFSET_CAP : p_count + n;
    endfunction

    // Multiply-accumulate one digit; once out of range the value freezes.
    function automatic void add_digit(input int unsigned d);
        logic [a2i_pkg::ACC_W-1:0] dd;
        logic [a2i_pkg::ACC_W-1:0] bb;
        dd = a2i_pkg::ACC_W'(d);
        bb = a2i_pkg::ACC_W'(p_base);
        p_seen = 1'b1;
        if (p_over || bb == 0) return;
        if (p_acc > ({a2i_pkg::ACC_W{1'b1}} - dd) / bb)
            p_over = 1'b1;
        else
            p_acc = p_acc * bb + dd;
    endfunction

    // Builds the result item for the number that just ended.
    function automatic a2i_pkg::result_t close_number(input int unsigned end_pos);
        a2i_pkg::result_t r;
        logic [a2i_pkg::ACC_W-1:0] lim;
        logic [a2i_pkg::ACC_W-1:0] plain;
        r = '0;
        if (p_seen)
        begin
            plain = p_neg ? a2i_pkg::ACC_W'(0) - p_acc : p_acc;
            if (cfg_signed)
            begin
                lim = p_neg ? a2i_pkg::LIM_NEG : a2i_pkg::LIM_POS;
                r.overflow = p_over || (p_acc > lim);
                r.value = r.overflow ? lim : plain;
            end
            else
            begin
                r.overflow = p_over;
                r.value = p_over ? {a2i_pkg::ACC_W{1'b1}} : plain;
            end
            r.end_offset = a2i_pkg::OFS_W'(end_pos);
            r.any_digits = 1'b1;
        end
        p_phase = a2i_pkg::PH_DONE;
        return r;
    endfunction

    function automatic bit digit_step(input logic [7:0] c, output a2i_pkg::result_t r);
        int unsigned d;
        d = digit_value(c);
        r = '0;
        if (d < p_base)
        begin
            add_digit(d);
            bump(1);
            p_phase = a2i_pkg::PH_DIGITS;
            return 1'b0;
        end
        r = close_number(p_count);
        return 1'b1;
    endfunction

    // First character after white space and sign: a leading zero may be a prefix.
    function automatic bit body_start(input logic [7:0] c, output a2i_pkg::result_t r);
        r = '0;
        if ((p_base == a2i_pkg::BASE_AUTO || p_base == a2i_pkg::BASE_HEX) &&
            c == a2i_pkg::CH_ZERO)
        begin
            p_acc = '0;
            p_seen = 1'b1;
            bump(1);
            p_phase = a2i_pkg::PH_ZERO;
            return 1'b0;
        end
        if (p_base == a2i_pkg::BASE_AUTO) p_base = a2i_pkg::BASE_DEC;
        return digit_step(c, r);
    endfunction

    // Advances the model by one character; returns 1 when a result is due.
    function automatic bit parse_char(input logic [7:0] c, input bit start,
                                      output a2i_pkg::result_t r);
        int unsigned d;
        r = '0;
        if (start)
        begin
            p_acc = '0;
            p_neg = 1'b0;
            p_seen = 1'b0;
            p_over = 1'b0;
            p_count = 0;
            p_base = cfg_radix;
            p_phase = a2i_pkg::PH_LEAD;
            if (cfg_radix == a2i_pkg::BASE_ONE || cfg_radix > a2i_pkg::BASE_MAX)
            begin
                r = close_number(0);
                return 1'b1;
            end
        end
        case (p_phase)
            a2i_pkg::PH_LEAD:
            begin
                if (c == a2i_pkg::CH_SPACE || (c >= a2i_pkg::CH_TAB && c <= a2i_pkg::CH_CR))
                begin
                    bump(1);
                    return 1'b0;
                end
                if (c == a2i_pkg::CH_MINUS || c == a2i_pkg::CH_PLUS)
                begin
                    p_neg = (c == a2i_pkg::CH_MINUS);
                    bump(1);
                    p_phase = a2i_pkg::PH_SIGNED;
                    return 1'b0;
                end
                return body_start(c, r);
            end
            a2i_pkg::PH_SIGNED: return body_start(c, r);
            a2i_pkg::PH_ZERO:
            begin
                if (c == a2i_pkg::CH_LO_X || c == a2i_pkg::CH_UP_X)
                begin
                    p_base = a2i_pkg::BASE_HEX;
                    p_phase = a2i_pkg::PH_XSEEN;
                    return 1'b0;
                end
                if (p_base == a2i_pkg::BASE_AUTO) p_base = a2i_pkg::BASE_OCT;
                return digit_step(c, r);
            end
            a2i_pkg::PH_XSEEN:
            begin
                // A prefix with no hex digit after it parses as the zero alone.
                d = digit_value(c);
                if (d < 16)
                begin
                    add_digit(d);
                    bump(2);
                    p_phase = a2i_pkg::PH_DIGITS;
                    return 1'b0;
                end
                r = close_number(p_count);
                return 1'b1;
            end
            a2i_pkg::PH_DIGITS: return digit_step(c, r);
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one character item and records the result it is due to cause.
    task automatic send_char(input logic [7:0] c, input bit start);
        int gap;
        a2i_pkg::result_t r;
        gap = src_idle ? $urandom_range(0, 14) : 0;
        repeat (gap)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid <= 1'b1;
        chars.ch    <= c;
        chars.first <= start;
        do @(posedge clk); while (!chars.ready);
        chars_sent++;
        if (parse_char(c, start, r)) parse_q.push_back(r);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    endtask

    // Stops the input and waits until every due result has come out.
    task automatic settle();
        chars.valid <= 1'b0;
        while (parse_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [a2i_pkg::CFG_IDX_W-1:0] idx,
                             input logic [a2i_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == a2i_pkg::REG_RADIX) cfg_radix = data[a2i_pkg::BASE_W-1:0];
        else cfg_signed = data[0];
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [a2i_pkg::BASE_W-1:0] radix, input bit sgn);
        settle();
        write_reg(a2i_pkg::REG_RADIX, radix);
        write_reg(a2i_pkg::REG_SIGNED, a2i_pkg::CFG_DATA_W'(sgn));
    endtask

    // Compares one accepted result item with the oldest one due.
    task automatic check_result();
        a2i_pkg::result_t got;
        a2i_pkg::result_t want;
        got.value      = results.value;
        got.end_offset = results.end_offset;
        got.any_digits = results.any_digits;
        got.overflow   = results.overflow;
        results_seen++;
        if (parse_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: result with none due: value %h end %0d digits %0b over %0b",
                         $time, got.value, got.end_offset, got.any_digits, got.overflow);
            return;
        end
        want = parse_q.pop_front();
        if (got.value !== want.value || got.end_offset !== want.end_offset ||
            got.any_digits !== want.any_digits || got.overflow !== want.overflow)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("%0t: mismatch: expected value %h end %0d digits %0b over %0b",
                         $time, want.value, want.end_offset, want.any_digits,
                         want.overflow);
                $display("%0t:           got value %h end %0d digits %0b over %0b",
                         $time, got.value, got.end_offset, got.any_digits,
                         got.overflow);
            end
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin : result_sink
        int stall;
        int n;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                results.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            stall = sink_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!results.valid);
            check_result();
        end
    end

    // ------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------

    // Picks a byte that ends a number in the given base.
    function automatic logic [7:0] pick_stop(input int eff);
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'($urandom_range(128, 255));
            default:
            begin
                do c = 8'($urandom_range(0, 127)); while (digit_value(c) < eff);
                return c;
            end
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return a2i_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? a2i_pkg::CH_UP_OFS : a2i_pkg::CH_LO_OFS) + 8'(d);
    endfunction

    // Digit strings at the edges of the signed and unsigned ranges.
    function automatic string edge_digits(input int eff);
        if (eff == 10)
            case ($urandom_range(0, 4))
                0: return "9223372036854775807";
                1: return "9223372036854775808";
                2: return "18446744073709551615";
                3: return "18446744073709551616";
                default: return "99999999999999999999";
            endcase
        case ($urandom_range(0, 3))
            0: return "7fffffffffffffff";
            1: return "8000000000000000";
            2: return "FFFFFFFFFFFFFFFF";
            default: return "10000000000000000";
        endcase
    endfunction

    // Sends one random string, mostly a well-formed number, and returns how
    // many characters went out for it.
    task automatic send_number(output int sent);
        logic [7:0] txt[$];
        string s;
        int eff;
        int len;
        int i;
        int d;
        int tail;
        bit auto_base;
        bit bad_base;
        bit lead_nz;
        bit broken;
        auto_base = (cfg_radix == a2i_pkg::BASE_AUTO);
        bad_base  = (cfg_radix == a2i_pkg::BASE_ONE || cfg_radix > a2i_pkg::BASE_MAX);
        eff = (bad_base || auto_base) ? 10 : int'(cfg_radix);
        broken = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise.
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    txt.push_back($urandom_range(0, 1) ? a2i_pkg::CH_SPACE
                                  : 8'($urandom_range(a2i_pkg::CH_TAB, a2i_pkg::CH_CR)));
            case ($urandom_range(0, 3))
                0: txt.push_back(a2i_pkg::CH_MINUS);
                1: txt.push_back(a2i_pkg::CH_PLUS);
                default: ;
            endcase
            lead_nz = auto_base;
            if ((auto_base || cfg_radix == a2i_pkg::BASE_HEX) && $urandom_range(0, 2) == 0)
            begin
                txt.push_back(a2i_pkg::CH_ZERO);
                lead_nz = 1'b0;
                if ($urandom_range(0, 3) != 0)
                begin
                    txt.push_back($urandom_range(0, 1) ? a2i_pkg::CH_LO_X : a2i_pkg::CH_UP_X);
                    eff = 16;
                end
                else if (auto_base)
                begin
                    eff = 8;
                end
            end
            d = $urandom_range(0, 9);
            if (d == 9 && (eff == 10 || eff == 16))
            begin
                s = edge_digits(eff);
                for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
            end
            else
            begin
                if (d == 0) len = 0;
                else if (d <= 6) len = d;
                else if (d == 7) len = $urandom_range(7, 14);
                else len = $urandom_range(15, 30);
                for (i = 0; i < len; i++)
                    txt.push_back(digit_char((i == 0 && lead_nz) ? $urandom_range(1, eff - 1)
                                                                : $urandom_range(0, eff - 1)));
            end
            // Now and then the string stops short and the next start abandons it.
            broken = ($urandom_range(0, 7) == 0);
            if (!broken) txt.push_back(pick_stop(eff));
        end
        sent = txt.size();
        for (i = 0; i < txt.size(); i++) send_char(txt[i], i == 0);
        // Trailing characters after the end are ignored.
        if (!broken && $urandom_range(0, 3) == 0)
        begin
            tail = $urandom_range(1, 2);
            repeat (tail) send_char(8'($urandom_range(0, 255)), 1'b0);
            sent += tail;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: detected base, signed limits.
    task automatic test_reset_defaults();
        send_char("5", 1'b0);          // no string started yet
        send_text("0xg");              // prefix with no hex digit
        send_text(" +7");
        send_char(8'h00, 1'b0);        // NUL ends the number
        send_char("9", 1'b0);          // after the result, ignored
        send_text("017");              // octal
        send_char(8'hFF, 1'b0);        // byte above 127 ends the number
        send_text("12");               // abandoned by the next start
        send_text("-z");               // no digits at all
        send_text("-0X1f");
        send_char(a2i_pkg::CH_SPACE, 1'b0);
    endtask

    // Radix 1 and radix above 36 give an empty result at once.
    task automatic test_invalid_radix();
        set_config(a2i_pkg::BASE_ONE, 1'b1);
        send_text("12;");
        set_config({a2i_pkg::BASE_W{1'b1}}, 1'b0);
        send_text("7");
    endtask

    // The base is latched at the start, the sign mode taken at the end.
    task automatic test_config_mid_string();
        set_config(a2i_pkg::BASE_AUTO, 1'b1);
        send_text("-5");
        set_config(6'd2, 1'b0);
        send_char("9", 1'b0);
        send_char(";", 1'b0);
    endtask

    // A string longer than the offset counter can hold.
    task automatic test_offset_saturation();
        set_config(a2i_pkg::BASE_DEC, 1'b0);
        src_idle = 1'b0;
        send_char(a2i_pkg::CH_SPACE, 1'b1);
        repeat (OFFSET_CAP) send_char(a2i_pkg::CH_SPACE, 1'b0);
        send_char(a2i_pkg::CH_MINUS, 1'b0);
        send_char("4", 1'b0);
        send_char("2", 1'b0);
        send_char(";", 1'b0);
        src_idle = 1'b1;
    endtask

    // Random numbers across base and sign settings, with and without idling.
    task automatic test_random_phases();
        logic [a2i_pkg::BASE_W-1:0] radix_set[9];
        bit sign_set[9];
        int quota[9];
        int ph;
        int total;
        int n;
        radix_set = '{a2i_pkg::BASE_AUTO, a2i_pkg::BASE_DEC, a2i_pkg::BASE_HEX, 6'd2,
                      a2i_pkg::BASE_MAX, a2i_pkg::BASE_OCT, a2i_pkg::BASE_AUTO,
                      {a2i_pkg::BASE_W{1'b1}}, a2i_pkg::BASE_ONE};
        sign_set  = '{1, 0, 1, 0, 1, 0, 0, 1, 0};
        quota     = '{25, 20, 20, 20, 20, 20, 25, 15, 15};
        for (ph = 0; ph < 9; ph++)
        begin
            set_config(radix_set[ph], sign_set[ph]);
            src_idle  = (ph % 4 != 3);
            sink_idle = (ph % 4 != 3) && (ph % 4 != 1);
            total = 0;
            while (total < quota[ph])
            begin
                send_number(n);
                total += n;
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // The receiver holds off while characters keep coming, so the input stalls.
    task automatic test_backpressure();
        set_config(a2i_pkg::BASE_DEC, 1'b1);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_cycles = 120;
        repeat (40)
        begin
            send_char(a2i_pkg::CH_ZERO + 8'($urandom_range(1, 9)), 1'b1);
            send_char(";", 1'b0);
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // A number with no terminator never produces a result.
    task automatic test_unterminated();
        set_config(a2i_pkg::BASE_AUTO, 1'b1);
        send_text("  12");
    endtask

    // Main sequence.
    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        chars.valid <= 1'b0;
        chars.ch    <= '0;
        chars.first <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_invalid_radix();
        test_config_mid_string();
        test_offset_saturation();
        test_random_phases();
        test_backpressure();
        test_unterminated();
        settle();

        $display("Checked %0d parse results from %0d characters with %0d register writes.",
                 results_seen, chars_sent, cfg_writes);
        $display("Bases auto, 2, 8, 10, 16, 36 and invalid, both sign modes, output hold-off.");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/a2i_pkg.sv
rtl/a2i_if.sv
rtl/a2i_step.sv
rtl/ascii_to_int64_parser.sv
rtl/a2i_checker.sv
test/ascii_to_int64_parser_tb.sv
